// ===== hdl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// Types, codes and constants shared by the hash table modules.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int LOG2_SLOTS_DEF = 10;
  localparam int VALUE_BITS_DEF = 16;
  localparam int LOG2_WIDTH     = 4;
  localparam logic [LOG2_WIDTH-1:0] TABLE_LOG2_RESET = 4'd10;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NULL_KEY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] key_hash;
    logic [15:0] value_in;
    logic [10:0] slot_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value_out;
    logic [9:0]  slot_out;
  } rsp_t;

  // Front-end verdict on one request, carried through the command queue.
  typedef struct packed {
    logic        null_key;
    logic        rm_valid;
    logic [1:0]  mode;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] key_hash;
    logic [15:0] value_in;
    logic [9:0]  slot_in;
  } cmd_t;

endpackage

// ===== hdl/oaht_front.sv =====
// ----------------------------------------------------------------------------
// oaht_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module oaht_front #(
  parameter int LOG2_SLOTS = oaht_pkg::LOG2_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  oaht_pkg::req_t                    req,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [oaht_pkg::LOG2_WIDTH-1:0]   size_log2,
  output oaht_pkg::cmd_t                    cmd,
  output logic                              cmd_valid,
  input  logic                              cmd_ready
);
  import oaht_pkg::*;

  // Two-entry queue.
  cmd_t       q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  cmd_t       c;
  logic       push;
  logic       pop;
  logic [LOG2_SLOTS:0] size_ext;

  always_comb begin
    size_ext = (LOG2_SLOTS+1)'(1) << size_log2;
    c.mode     = req.mode;
    c.key_hi   = req.key_hi;
    c.key_lo   = req.key_lo;
    c.key_hash = req.key_hash;
    c.value_in = req.value_in;
    c.slot_in  = req.slot_in[9:0];
    c.null_key = (req.key_hi == '0) && (req.key_lo == '0) &&
                 ((req.mode == MODE_INSERT) || (req.mode == MODE_FIND));
    c.rm_valid = !req.slot_in[10] && (32'(req.slot_in[9:0]) < 32'(size_ext));
  end

  assign req_ready = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/oaht_back.sv =====
// ----------------------------------------------------------------------------
// oaht_back
// Runs probes against the slot memories, one slot read per probe; it takes a new request only when idle.
// ----------------------------------------------------------------------------
module oaht_back #(
  parameter int LOG2_SLOTS = oaht_pkg::LOG2_SLOTS_DEF,
  parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  oaht_pkg::cmd_t                  cmd,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  logic [oaht_pkg::LOG2_WIDTH-1:0] size_log2,
  output oaht_pkg::rsp_t                  rsp,
  output logic                            rsp_valid,
  input  logic                            rsp_ready
);
  import oaht_pkg::*;

  localparam int DEPTH = 1 << LOG2_SLOTS;

  typedef enum logic [5:0] {
    S_WIPE  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_DONE  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_t;

  state_t state;

  logic [1:0]            mark_mem [DEPTH];
  logic [63:0]           khi_mem  [DEPTH];
  logic [63:0]           klo_mem  [DEPTH];
  logic [VALUE_BITS-1:0] val_mem  [DEPTH];

  cmd_t                  cur;
  rsp_t                  res;
  logic [LOG2_SLOTS-1:0] mask;
  logic [LOG2_SLOTS-1:0] addr;
  logic [LOG2_SLOTS:0]   probes;
  logic [1:0]            rd_mark;
  logic [63:0]           rd_khi;
  logic [63:0]           rd_klo;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  wr_en;
  logic [LOG2_SLOTS-1:0] wr_addr;
  logic [1:0]            wr_mark;
  logic                  wr_kv;
  logic [LOG2_SLOTS-1:0] size_m1;
  logic [LOG2_SLOTS:0]   size_n;
  logic                  probe_hit;
  logic                  rst_wipe;

  assign size_n  = (LOG2_SLOTS+1)'(1) << size_log2;
  assign size_m1 = LOG2_SLOTS'(size_n - 1'b1);

  // The probe ends here: a free slot for insert, an empty slot or a match for find.
  assign probe_hit = (cur.mode == MODE_INSERT) ? (rd_mark != MARK_USED) :
                     (rd_mark == MARK_EMPTY ||
                      (rd_mark == MARK_USED && rd_khi == cur.key_hi &&
                       rd_klo == cur.key_lo));

  always_ff @(posedge clk) begin
    rd_mark <= mark_mem[addr];
    rd_khi  <= khi_mem[addr];
    rd_klo  <= klo_mem[addr];
    rd_val  <= val_mem[addr];
    if (wr_en) begin
      mark_mem[wr_addr] <= wr_mark;
    end
    if (wr_kv) begin
      khi_mem[wr_addr] <= cur.key_hi;
      klo_mem[wr_addr] <= cur.key_lo;
      val_mem[wr_addr] <= VALUE_BITS'(cur.value_in);
    end
  end

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    wr_en   = 1'b0;
    wr_kv   = 1'b0;
    wr_addr = addr;
    wr_mark = MARK_EMPTY;
    case (state)
      S_WIPE: begin
        wr_en = 1'b1;
      end
      S_DONE: begin
        // Tombstone write for remove requests.
        if (cur.mode == MODE_REMOVE && cur.rm_valid) begin
          wr_en   = 1'b1;
          wr_addr = LOG2_SLOTS'(cur.slot_in);
          wr_mark = MARK_TOMB;
        end
      end
      S_CHECK: begin
        if (cur.mode == MODE_INSERT && rd_mark != MARK_USED) begin
          wr_en   = 1'b1;
          wr_kv   = 1'b1;
          wr_mark = MARK_USED;
        end
      end
      default: begin
      end
    endcase
  end

  // Marks the wipe that follows reset, which gives no response.
  always_ff @(posedge clk) begin
    if (rst) begin
      rst_wipe <= 1'b1;
    end else if (state == S_IDLE) begin
      rst_wipe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WIPE;
      addr      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_WIPE: begin
          addr <= addr + 1'b1;
          // A clear reports once its wipe is done.
          if (addr == LOG2_SLOTS'(DEPTH - 1)) begin
            state <= rst_wipe ? S_IDLE : S_HOLD;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            mask   <= size_m1;
            probes <= '0;
            res    <= '{status: (cmd.null_key ? ST_NULL_KEY : ST_OK),
                        value_out: '0, slot_out: '0};
            if (cmd.mode == MODE_CLEAR) begin
              addr  <= '0;
              state <= S_WIPE;
            end else begin
              addr <= LOG2_SLOTS'(cmd.key_hash) & size_m1;
              if (cmd.null_key || cmd.mode == MODE_REMOVE) begin
                state <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (probe_hit) begin
            state <= S_DONE;
            if (cur.mode == MODE_INSERT) begin
              res <= '{status: ST_OK, value_out: '0, slot_out: 10'(addr)};
            end else if (rd_mark == MARK_EMPTY) begin
              res <= '{status: ST_NOT_FOUND, value_out: '0, slot_out: '0};
            end else begin
              res <= '{status: ST_OK, value_out: 16'(rd_val), slot_out: 10'(addr)};
            end
          end else if (probes == size_n - 1'b1) begin
            res   <= '{status: ((cur.mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND),
                       value_out: '0, slot_out: '0};
            state <= S_DONE;
          end else begin
            probes <= probes + 1'b1;
            addr   <= (addr + 1'b1) & mask;
            state  <= S_READ;
          end
        end
        S_DONE: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (!rsp_valid) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/open_addressing_hash_table.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Hash table with linear probing and tombstones over 128-bit keys.
// ----------------------------------------------------------------------------
// Channel   Signals                           Direction
// req       req_valid / req_ready / req       in : mode, key, hash, value, slot
// rsp       rsp_valid / rsp_ready / rsp       out: status, value, slot
// cfg       cfg_valid / cfg_ready / cfg_data  in : table_log2
//
// Each probe is one read of the slot memories, in states S_READ and S_CHECK;
// a request then passes S_DONE and S_HOLD. Remove and null-key requests skip
// the probe, and a clear sweeps all 2**LOG2_SLOTS entries of the mark memory.
// After reset the same sweep runs before the first request starts; requests
// still queue in the two-entry front queue. A stalled response holds the
// back end, while the front keeps accepting until its queue is full.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
  parameter int LOG2_SLOTS = oaht_pkg::LOG2_SLOTS_DEF,
  parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  oaht_pkg::req_t                  req,
  input  logic                            req_valid,
  output logic                            req_ready,
  output oaht_pkg::rsp_t                  rsp,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  logic [oaht_pkg::LOG2_WIDTH-1:0] cfg_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready
);
  import oaht_pkg::*;

  logic [LOG2_WIDTH-1:0] table_log2;
  logic [LOG2_WIDTH-1:0] size_log2;
  cmd_t                  cmd;
  logic                  cmd_valid;
  logic                  cmd_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_log2 <= TABLE_LOG2_RESET;
    end else if (cfg_valid) begin
      table_log2 <= cfg_data;
    end
  end

  // Clamp the configured size into the range the memories support.
  always_comb begin
    if (table_log2 < 4'd2) begin
      size_log2 = 4'd2;
    end else if (32'(table_log2) > LOG2_SLOTS) begin
      size_log2 = LOG2_WIDTH'(LOG2_SLOTS);
    end else begin
      size_log2 = table_log2;
    end
  end

  oaht_front #(.LOG2_SLOTS(LOG2_SLOTS)) u_front (
    .clk, .rst, .req, .req_valid, .req_ready, .size_log2,
    .cmd, .cmd_valid, .cmd_ready
  );

  oaht_back #(.LOG2_SLOTS(LOG2_SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready, .size_log2,
    .rsp, .rsp_valid, .rsp_ready
  );

endmodule
